[design/plucked_string_synth_defines.svh]
// assertion macros for the plucked string synthesizer
`ifndef PLUCKED_STRING_SYNTH_DEFINES_SVH
`define PLUCKED_STRING_SYNTH_DEFINES_SVH

`ifndef SYNTH
`define PSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSS_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);
`else
`define PSS_ASSERT(lbl, prop, msg)
`define PSS_ASSERT_NEXT(lbl, trig, prop, msg)
`endif

`endif

[design/pss_pkg.sv]
// shared types and constants for the plucked string synthesizer
`default_nettype none

package pss_pkg;

    // input beat codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PLUCK = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_IDX_PERIOD_LEN     = 3'd0;
    localparam logic [2:0] CFG_IDX_DECAY_GAIN     = 3'd1;
    localparam logic [2:0] CFG_IDX_VOLUME_GAIN    = 3'd2;
    localparam logic [2:0] CFG_IDX_ELECTRIC_MODE  = 3'd3;
    localparam logic [2:0] CFG_IDX_CLIP_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_IDX_CLIP_VALUE     = 3'd5;
    localparam logic [2:0] CFG_IDX_NOTE_DURATION  = 3'd6;

    // configuration reset values
    localparam logic [10:0] RST_PERIOD_LEN     = 11'd134;
    localparam logic [15:0] RST_DECAY_GAIN     = 16'd65470;
    localparam logic [11:0] RST_VOLUME_GAIN    = 12'd2048;
    localparam logic        RST_ELECTRIC_MODE  = 1'b0;
    localparam logic [7:0]  RST_CLIP_THRESHOLD = 8'd105;
    localparam logic [7:0]  RST_CLIP_VALUE     = 8'd180;
    localparam logic [15:0] RST_NOTE_DURATION  = 16'd44100;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] noise_index;
        logic [7:0] noise_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] sample_out;
        logic [7:0] raw_value;
        logic       last_of_note;
        logic       note_done;
    } out_beat_t;

    typedef struct packed {
        logic [10:0] period_len;
        logic [15:0] decay_gain;
        logic [11:0] volume_gain;
        logic        electric_mode;
        logic [7:0]  clip_threshold;
        logic [7:0]  clip_value;
        logic [15:0] note_duration;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_PLUCK,
        CMD_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [9:0] index;
        logic [7:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

[design/pss_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/pss_front.sv]
// input stage: decodes beats into commands and queues them for the back end
`default_nettype none

module pss_front #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pss_pkg::in_beat_t in_data,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output pss_pkg::cmd_t         cmd
);

    import pss_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    cmd_t       dec;
    logic       push, pop;

    // classify: unknown codes and out of range loads are dropped
    always_comb
    begin
        keep      = 1'b0;
        dec.op    = CMD_TICK;
        dec.index = in_data.noise_index;
        dec.value = in_data.noise_byte;
        case (in_data.req_type)
            REQ_LOAD:
            begin
                dec.op = CMD_LOAD;
                keep   = (32'(in_data.noise_index) < 32'(MAX_LEN));
            end
            REQ_PLUCK:
            begin
                dec.op = CMD_PLUCK;
                keep   = 1'b1;
            end
            REQ_TICK:
            begin
                dec.op = CMD_TICK;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

[design/pss_back.sv]
// back end: noise store, delay line, pluck copy and string filter sequencer
`default_nettype none
`include "plucked_string_synth_defines.svh"

module pss_back #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pss_pkg::cfg_t     cfg,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire pss_pkg::cmd_t     cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pss_pkg::out_beat_t     out_data
);

    import pss_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    back_state_t state_reg, state_next;

    logic [AW-1:0] pos_reg, pos_next;
    logic [15:0]   count_reg, count_next;
    logic          playing_reg, playing_next;
    logic [LW-1:0] note_len_reg, note_len_next;
    logic [LW-1:0] copy_cnt_reg, copy_cnt_next;
    logic          copy_pend_reg, copy_pend_next;
    logic          silent_reg, silent_next;
    logic          out_valid_reg, out_valid_next;

    logic [AW-1:0] pend_addr_reg;
    logic [7:0]    a_reg;
    logic [24:0]   prod_reg;
    out_beat_t     out_reg;

    logic          noise_we;
    logic [AW-1:0] noise_waddr, noise_raddr;
    logic [7:0]    noise_wdata, noise_rdata;
    logic          dly_we;
    logic [AW-1:0] dly_waddr, dly_raddr;
    logic [7:0]    dly_wdata, dly_rdata;

    logic [LW-1:0] len_sat;
    logic [LW-1:0] nxt_wide;
    logic [AW-1:0] nxt;
    logic          copy_more;
    logic          emit_fire;
    logic [7:0]    y;
    logic [7:0]    v;
    logic [19:0]   vol;
    logic [15:0]   count_inc;
    logic [15:0]   dur;
    logic          last;
    out_beat_t     beat;

    pss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_noise_ram (
        .clk   (clk),
        .we    (noise_we),
        .waddr (noise_waddr),
        .wdata (noise_wdata),
        .raddr (noise_raddr),
        .rdata (noise_rdata)
    );

    pss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    // ring length saturated to the legal range
    always_comb
    begin
        if (cfg.period_len < 11'd2)
        begin
            len_sat = LW'(2);
        end
        else if (32'(cfg.period_len) > 32'(MAX_LEN))
        begin
            len_sat = LW'(MAX_LEN);
        end
        else
        begin
            len_sat = LW'(cfg.period_len);
        end
    end

    assign nxt_wide  = LW'(pos_reg) + LW'(1);
    assign nxt       = (nxt_wide == note_len_reg) ? '0 : AW'(nxt_wide);
    assign copy_more = (copy_cnt_reg < note_len_reg);
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // filter output, clip and volume
    assign y         = prod_reg[24:17];
    assign v         = (cfg.electric_mode && (y < cfg.clip_threshold)) ? cfg.clip_value : y;
    assign vol       = 20'(v) * 20'(cfg.volume_gain);
    assign count_inc = count_reg + 16'd1;
    assign dur       = (cfg.note_duration == 16'd0) ? 16'd1 : cfg.note_duration;
    assign last      = (count_inc >= dur);

    always_comb
    begin
        if (silent_reg)
        begin
            beat.sample_out   = 8'd0;
            beat.raw_value    = 8'd0;
            beat.last_of_note = 1'b0;
            beat.note_done    = 1'b1;
        end
        else
        begin
            beat.sample_out   = vol[19:12];
            beat.raw_value    = y;
            beat.last_of_note = last;
            beat.note_done    = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_PLUCK: state_next = ST_COPY;
                        CMD_TICK:  state_next = playing_reg ? ST_RD_A : ST_EMIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COPY:
            begin
                if (!copy_more && !copy_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = ST_MUL;
            ST_MUL:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and register updates
    always_comb
    begin
        cmd_ready      = (state_reg == ST_IDLE);
        noise_we       = (state_reg == ST_IDLE) && cmd_valid && (cmd.op == CMD_LOAD);
        noise_waddr    = AW'(cmd.index);
        noise_wdata    = cmd.value;
        noise_raddr    = AW'(copy_cnt_reg);
        dly_raddr      = (state_reg == ST_RD_B) ? nxt : pos_reg;
        dly_we         = 1'b0;
        dly_waddr      = pos_reg;
        dly_wdata      = y;

        pos_next       = pos_reg;
        count_next     = count_reg;
        playing_next   = playing_reg;
        note_len_next  = note_len_reg;
        copy_cnt_next  = copy_cnt_reg;
        copy_pend_next = copy_pend_reg;
        silent_next    = silent_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_PLUCK:
                        begin
                            note_len_next  = len_sat;
                            copy_cnt_next  = '0;
                            copy_pend_next = 1'b0;
                            pos_next       = '0;
                            count_next     = 16'd0;
                            playing_next   = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            silent_next = !playing_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                dly_we         = copy_pend_reg;
                dly_waddr      = pend_addr_reg;
                dly_wdata      = noise_rdata;
                copy_pend_next = copy_more;
                if (copy_more)
                begin
                    copy_cnt_next = copy_cnt_reg + LW'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    if (!silent_reg)
                    begin
                        dly_we     = 1'b1;
                        pos_next   = nxt;
                        count_next = count_inc;
                        if (last)
                        begin
                            playing_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= 16'd0;
            playing_reg   <= 1'b0;
            note_len_reg  <= LW'(2);
            copy_cnt_reg  <= '0;
            copy_pend_reg <= 1'b0;
            silent_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            playing_reg   <= playing_next;
            note_len_reg  <= note_len_next;
            copy_cnt_reg  <= copy_cnt_next;
            copy_pend_reg <= copy_pend_next;
            silent_reg    <= silent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= AW'(copy_cnt_reg);
        if (state_reg == ST_RD_B)
        begin
            a_reg <= dly_rdata;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 25'({1'b0, a_reg} + {1'b0, dly_rdata}) * 25'(cfg.decay_gain);
        end
        if (emit_fire)
        begin
            out_reg <= beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PSS_ASSERT(a_pos_in_ring, playing_reg |-> (LW'(pos_reg) < note_len_reg), "ring position past note length")
    `PSS_ASSERT(a_len_min, note_len_reg >= LW'(2), "note length below two")
    `PSS_ASSERT(a_copy_bound, (state_reg == ST_COPY) |-> (copy_cnt_reg <= note_len_reg), "copy overran ring")
    `PSS_ASSERT_NEXT(a_mul_order, (state_reg == ST_RD_B), (state_reg == ST_MUL), "tick read sequence broken")

endmodule

`default_nettype wire

[design/plucked_string_synth.sv]
// top level of the plucked string synthesizer: config registers, front end, back end
//
//  channel | signals                     | beat
//  --------+-----------------------------+------------------------------------
//  in      | in_valid in_ready in_data   | load noise byte, pluck or sample tick
//  out     | out_valid out_ready out_data| one sample per tick
//  cfg     | cfg_valid cfg_ready         | register write, index and data
//          | cfg_index cfg_data          |
//
// load: one noise ram write; pluck: latched length, then noise copied into the ring
// tick: RD_A, RD_B, MUL, then EMIT, a sequence set by the single read port of the delay
// ring (two reads) and the registered loop multiply; a silent tick goes straight to EMIT
// a two-entry command queue lets input beats be taken while the back end works or the
// output register waits; cfg_ready is always high
// reset clears control state only; both rams start undefined, no clearing pass
`default_nettype none

module plucked_string_synth #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pss_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pss_pkg::out_beat_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    import pss_pkg::*;

    cfg_t cfg_reg;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_len     <= RST_PERIOD_LEN;
            cfg_reg.decay_gain     <= RST_DECAY_GAIN;
            cfg_reg.volume_gain    <= RST_VOLUME_GAIN;
            cfg_reg.electric_mode  <= RST_ELECTRIC_MODE;
            cfg_reg.clip_threshold <= RST_CLIP_THRESHOLD;
            cfg_reg.clip_value     <= RST_CLIP_VALUE;
            cfg_reg.note_duration  <= RST_NOTE_DURATION;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_PERIOD_LEN:     cfg_reg.period_len     <= cfg_data[10:0];
                CFG_IDX_DECAY_GAIN:     cfg_reg.decay_gain     <= cfg_data;
                CFG_IDX_VOLUME_GAIN:    cfg_reg.volume_gain    <= cfg_data[11:0];
                CFG_IDX_ELECTRIC_MODE:  cfg_reg.electric_mode  <= cfg_data[0];
                CFG_IDX_CLIP_THRESHOLD: cfg_reg.clip_threshold <= cfg_data[7:0];
                CFG_IDX_CLIP_VALUE:     cfg_reg.clip_value     <= cfg_data[7:0];
                CFG_IDX_NOTE_DURATION:  cfg_reg.note_duration  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pss_front #(.MAX_LEN(MAX_LEN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    pss_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[tb/sv/tb_plucked_string_synth.sv]
// testbench for plucked_string_synth: directed and random beats checked against a local predictor
`default_nettype none

module tb_plucked_string_synth;
    import pss_pkg::*;

    localparam int RING_MAX = 1024;
    localparam int LONG_LEN = 96;
    localparam int SETTLE_CYCLES = RING_MAX + 64;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ROUNDS = 6;
    localparam int BEATS_PER_ROUND = 36;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_beat_t in_data;
    logic out_valid;
    logic out_ready;
    out_beat_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    cfg_t cfg_shadow;
    logic [7:0] noise_mem [RING_MAX];
    logic [7:0] ring_mem [RING_MAX];
    int unsigned ring_pos;
    int unsigned note_len;
    logic [15:0] sample_count;
    bit note_playing;

    bit noise_loaded [RING_MAX];
    out_beat_t expected_samples [$];
    bit quiet;
    bit hold_req;

    int unsigned fail_count;
    int unsigned samples_checked;
    int unsigned notes_ended;
    int unsigned silent_ticks;
    int unsigned clipped_samples;
    int unsigned plucks_seen;
    int unsigned loads_seen;
    int unsigned input_stalls;

    plucked_string_synth #(
        .MAX_LEN(RING_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned held_len(logic [10:0] p);
        if (p < 2)
        begin
            return 2;
        end
        if (p > RING_MAX)
        begin
            return RING_MAX;
        end
        return p;
    endfunction

    function automatic logic [15:0] reg_mask(logic [2:0] idx);
        case (idx)
            CFG_IDX_PERIOD_LEN:     return 16'h07FF;
            CFG_IDX_DECAY_GAIN:     return 16'hFFFF;
            CFG_IDX_VOLUME_GAIN:    return 16'h0FFF;
            CFG_IDX_ELECTRIC_MODE:  return 16'h0001;
            CFG_IDX_CLIP_THRESHOLD: return 16'h00FF;
            CFG_IDX_CLIP_VALUE:     return 16'h00FF;
            CFG_IDX_NOTE_DURATION:  return 16'hFFFF;
            default:                return 16'h0000;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    task automatic synth_step(input in_beat_t beat, output bit has_sample,
                              output out_beat_t sample);
        int unsigned pos;
        int unsigned nxt;
        int unsigned a;
        int unsigned b;
        int unsigned y;
        int unsigned v;
        int unsigned dur;
        has_sample = 1'b0;
        sample = '0;
        case (beat.req_type)
            REQ_LOAD:
            begin
                noise_mem[beat.noise_index] = beat.noise_byte;
                loads_seen++;
            end
            REQ_PLUCK:
            begin
                note_len = held_len(cfg_shadow.period_len);
                for (int i = 0; i < note_len; i++)
                begin
                    ring_mem[i] = noise_mem[i];
                end
                ring_pos = 0;
                sample_count = '0;
                note_playing = 1'b1;
                plucks_seen++;
            end
            REQ_TICK:
            begin
                has_sample = 1'b1;
                if (!note_playing)
                begin
                    sample.note_done = 1'b1;
                    silent_ticks++;
                end
                else
                begin
                    pos = ring_pos % note_len;
                    nxt = (pos + 1) % note_len;
                    a = ring_mem[pos];
                    b = ring_mem[nxt];
                    y = (((a + b) * cfg_shadow.decay_gain) >> 17) & 32'hFF;
                    ring_mem[pos] = y[7:0];
                    ring_pos = nxt;
                    v = y;
                    if (cfg_shadow.electric_mode && y < cfg_shadow.clip_threshold)
                    begin
                        v = cfg_shadow.clip_value;
                        clipped_samples++;
                    end
                    dur = (cfg_shadow.note_duration == 0) ? 1 : cfg_shadow.note_duration;
                    sample_count = sample_count + 16'd1;
                    sample.last_of_note = (sample_count >= dur);
                    if (sample.last_of_note)
                    begin
                        note_playing = 1'b0;
                    end
                    sample.sample_out = 8'((v * cfg_shadow.volume_gain) >> 12);
                    sample.raw_value = y[7:0];
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
    endtask

    // accepted beats: config shadow, sample check, prediction
    always @(posedge clk)
    begin
        out_beat_t want;
        out_beat_t pred;
        bit has_sample;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDX_PERIOD_LEN:     cfg_shadow.period_len = cfg_data[10:0];
                    CFG_IDX_DECAY_GAIN:     cfg_shadow.decay_gain = cfg_data;
                    CFG_IDX_VOLUME_GAIN:    cfg_shadow.volume_gain = cfg_data[11:0];
                    CFG_IDX_ELECTRIC_MODE:  cfg_shadow.electric_mode = cfg_data[0];
                    CFG_IDX_CLIP_THRESHOLD: cfg_shadow.clip_threshold = cfg_data[7:0];
                    CFG_IDX_CLIP_VALUE:     cfg_shadow.clip_value = cfg_data[7:0];
                    CFG_IDX_NOTE_DURATION:  cfg_shadow.note_duration = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_ready)
            begin
                input_stalls++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    note_failure($sformatf("unexpected sample: out=%0d raw=%0d last=%0b done=%0b",
                        out_data.sample_out, out_data.raw_value, out_data.last_of_note,
                        out_data.note_done));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (out_data.sample_out !== want.sample_out
                        || out_data.raw_value !== want.raw_value
                        || out_data.last_of_note !== want.last_of_note
                        || out_data.note_done !== want.note_done)
                    begin
                        note_failure($sformatf({"sample %0d: expected out=%0d raw=%0d last=%0b ",
                            "done=%0b, got out=%0d raw=%0d last=%0b done=%0b"},
                            samples_checked, want.sample_out, want.raw_value,
                            want.last_of_note, want.note_done, out_data.sample_out,
                            out_data.raw_value, out_data.last_of_note, out_data.note_done));
                    end
                    if (out_data.last_of_note === 1'b1)
                    begin
                        notes_ended++;
                    end
                    samples_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                synth_step(in_data, has_sample, pred);
                if (has_sample)
                begin
                    expected_samples.push_back(pred);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold when asked
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        int unsigned idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_run = 0;
            end
            else if (in_valid || expected_samples.size() != 0)
            begin
                idle_run++;
            end
            else
            begin
                idle_run = 0;
            end
        end
        $display("timeout: no beat accepted for %0d cycles, %0d samples outstanding",
                 idle_run, expected_samples.size());
        $display("plucked_string_synth regression: fail");
        $finish;
    end

    task automatic send_beat(input logic [1:0] kind, input logic [9:0] idx,
                             input logic [7:0] val);
        int unsigned gap;
        in_beat_t beat;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat.req_type = kind;
        beat.noise_index = idx;
        beat.noise_byte = val;
        in_data = beat;
        in_valid = 1'b1;
        if (kind == REQ_LOAD)
        begin
            noise_loaded[idx] = 1'b1;
        end
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_beat(REQ_TICK, 10'($urandom), 8'($urandom));
    endtask

    task automatic send_pluck();
        int unsigned len;
        len = held_len(cfg_shadow.period_len);
        for (int i = 0; i < len; i++)
        begin
            if (!noise_loaded[i])
            begin
                send_beat(REQ_LOAD, 10'(i), 8'($urandom));
            end
        end
        send_beat(REQ_PLUCK, 10'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data = val | (16'($urandom) & ~reg_mask(idx));
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // loads and plucks give no sample, so give the block time to finish a ring copy
    task automatic drain_and_settle();
        in_valid = 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_reset_silence();
        send_tick();
        send_beat(REQ_SPARE, 10'h3FF, 8'hFF);
        send_beat(REQ_LOAD, 10'd0, 8'd255);
        send_beat(REQ_LOAD, 10'd1023, 8'd0);
        send_tick();
    endtask

    task automatic test_directed_notes();
        drain_and_settle();
        write_reg(CFG_IDX_PERIOD_LEN, 16'd0);
        write_reg(CFG_IDX_DECAY_GAIN, 16'hFFFF);
        write_reg(CFG_IDX_VOLUME_GAIN, 16'd4095);
        write_reg(CFG_IDX_ELECTRIC_MODE, 16'd1);
        write_reg(CFG_IDX_CLIP_THRESHOLD, 16'd255);
        write_reg(CFG_IDX_CLIP_VALUE, 16'd255);
        write_reg(CFG_IDX_NOTE_DURATION, 16'd0);
        write_reg(CFG_IDX_SPARE, 16'($urandom));
        send_beat(REQ_LOAD, 10'd1, 8'd255);
        send_pluck();
        send_tick();
        send_tick();

        // pluck restarting a running note, zero decay, no clipping
        drain_and_settle();
        write_reg(CFG_IDX_PERIOD_LEN, 16'd3);
        write_reg(CFG_IDX_NOTE_DURATION, 16'd4);
        write_reg(CFG_IDX_DECAY_GAIN, 16'd0);
        write_reg(CFG_IDX_VOLUME_GAIN, 16'd2048);
        write_reg(CFG_IDX_CLIP_THRESHOLD, 16'd0);
        write_reg(CFG_IDX_CLIP_VALUE, 16'd0);
        send_beat(REQ_LOAD, 10'd2, 8'd0);
        send_pluck();
        send_tick();
        send_tick();
        send_pluck();
        send_tick();
        send_tick();

        // duration lowered below the count of a running note
        drain_and_settle();
        write_reg(CFG_IDX_NOTE_DURATION, 16'd1);
        send_tick();
        send_tick();
    endtask

    task automatic test_period_limits();
        drain_and_settle();
        write_reg(CFG_IDX_PERIOD_LEN, 16'(LONG_LEN));
        write_reg(CFG_IDX_DECAY_GAIN, 16'(RST_DECAY_GAIN));
        write_reg(CFG_IDX_VOLUME_GAIN, 16'd4095);
        write_reg(CFG_IDX_ELECTRIC_MODE, 16'd0);
        write_reg(CFG_IDX_NOTE_DURATION, 16'd12);
        send_pluck();
        repeat (14) send_tick();

        drain_and_settle();
        write_reg(CFG_IDX_PERIOD_LEN, 16'd2);
        send_pluck();
        repeat (8) send_tick();

        drain_and_settle();
        write_reg(CFG_IDX_PERIOD_LEN, 16'd1);
        send_pluck();
        repeat (6) send_tick();
    endtask

    task automatic test_output_backpressure();
        drain_and_settle();
        write_reg(CFG_IDX_PERIOD_LEN, 16'd5);
        write_reg(CFG_IDX_NOTE_DURATION, 16'hFFFF);
        write_reg(CFG_IDX_VOLUME_GAIN, 16'd3000);
        send_pluck();
        quiet = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_tick();
        quiet = 1'b0;
    endtask

    task automatic test_random_rounds();
        int unsigned r;
        logic [15:0] val;
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            drain_and_settle();
            quiet = (round % 3 == 2);

            case ($urandom_range(0, 9))
                0:       val = 16'd0;
                1:       val = 16'd1;
                2:       val = 16'(LONG_LEN);
                3:       val = 16'($urandom_range(2, LONG_LEN));
                default: val = 16'($urandom_range(2, 24));
            endcase
            write_reg(CFG_IDX_PERIOD_LEN, val);
            case ($urandom_range(0, 5))
                0:       val = 16'd0;
                1:       val = 16'hFFFF;
                2:       val = 16'($urandom);
                default: val = 16'($urandom_range(60000, 65535));
            endcase
            write_reg(CFG_IDX_DECAY_GAIN, val);
            case ($urandom_range(0, 5))
                0:       val = 16'd0;
                1:       val = 16'd4095;
                default: val = 16'($urandom_range(1, 4095));
            endcase
            write_reg(CFG_IDX_VOLUME_GAIN, val);
            write_reg(CFG_IDX_ELECTRIC_MODE, 16'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0:       val = 16'd0;
                1:       val = 16'd255;
                default: val = 16'($urandom_range(0, 255));
            endcase
            write_reg(CFG_IDX_CLIP_THRESHOLD, val);
            case ($urandom_range(0, 3))
                0:       val = 16'd0;
                1:       val = 16'd255;
                default: val = 16'($urandom_range(0, 255));
            endcase
            write_reg(CFG_IDX_CLIP_VALUE, val);
            case ($urandom_range(0, 7))
                0:       val = 16'd0;
                1:       val = 16'd1;
                2:       val = 16'hFFFF;
                default: val = 16'($urandom_range(2, 40));
            endcase
            write_reg(CFG_IDX_NOTE_DURATION, val);

            send_pluck();
            repeat (BEATS_PER_ROUND)
            begin
                r = $urandom_range(0, 99);
                if (r < 72)
                begin
                    send_tick();
                end
                else if (r < 79)
                begin
                    send_pluck();
                end
                else if (r < 96)
                begin
                    send_beat(REQ_LOAD, 10'($urandom), 8'($urandom));
                end
                else
                begin
                    send_beat(REQ_SPARE, 10'($urandom), 8'($urandom));
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        cfg_shadow.period_len = RST_PERIOD_LEN;
        cfg_shadow.decay_gain = RST_DECAY_GAIN;
        cfg_shadow.volume_gain = RST_VOLUME_GAIN;
        cfg_shadow.electric_mode = RST_ELECTRIC_MODE;
        cfg_shadow.clip_threshold = RST_CLIP_THRESHOLD;
        cfg_shadow.clip_value = RST_CLIP_VALUE;
        cfg_shadow.note_duration = RST_NOTE_DURATION;
        ring_pos = 0;
        note_len = 2;
        sample_count = '0;
        note_playing = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_silence();
        test_directed_notes();
        test_period_limits();
        test_output_backpressure();
        test_random_rounds();
        drain_and_settle();

        if (expected_samples.size() != 0)
        begin
            note_failure($sformatf("%0d expected samples never arrived",
                                   expected_samples.size()));
        end
        $display("covered %0d samples (%0d silent, %0d clipped, %0d note ends), %0d plucks, %0d loads",
                 samples_checked, silent_ticks, clipped_samples, notes_ended, plucks_seen,
                 loads_seen);
        $display("input held off for %0d cycles, %0d mismatches", input_stalls, fail_count);
        if (fail_count == 0)
        begin
            $display("plucked_string_synth regression: pass");
        end
        else
        begin
            $display("plucked_string_synth regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
